// ===== hw/rtl/adbs_pkg.sv =====
// Shared types, operation codes and helpers for the aged double bitmap set.
`timescale 1ns / 1ps

package adbs_pkg;

    // Operation codes carried in the input tuser field.
    typedef enum logic [2:0] {
        FN_INSERT   = 3'd0,
        FN_MERGE    = 3'd1,
        FN_CONTAINS = 3'd2,
        FN_SWAP     = 3'd3,
        FN_COUNT    = 3'd4,
        FN_READ     = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ACCESS,
        ST_MODIFY,
        ST_SWEEP,
        ST_COUNT,
        ST_COUNT_TAIL,
        ST_FINISH
    } state_t;

    // Port controls from the sequencer to the two map memories.
    typedef struct packed {
        logic rd_en;
        logic wr_zero;
        logic wr_one;
    } map_ctl_t;

    localparam int FUNC_W  = 3;
    localparam int ADDR_W  = 16;
    localparam int BIDX_W  = 7;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 11;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + {3'd0, v[i]};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/adbs_maps.sv =====
// Storage for the two bitmaps, one read and one write port on each.
`timescale 1ns / 1ps

module adbs_maps #(
    parameter int SET_BYTES = 128,
    parameter int AW        = 7
) (
    input  logic              clk,
    input  adbs_pkg::map_ctl_t ctl,
    input  logic [AW-1:0]     addr,
    input  logic [7:0]        wdata_zero,
    input  logic [7:0]        wdata_one,
    output logic [7:0]        rdata_zero,
    output logic [7:0]        rdata_one
);
    import adbs_pkg::*;

    logic [7:0] mem_zero [SET_BYTES];
    logic [7:0] mem_one  [SET_BYTES];
    logic [7:0] rdata_zero_reg;
    logic [7:0] rdata_one_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_zero)
        begin
            mem_zero[addr] <= wdata_zero;
        end
        if (ctl.rd_en)
        begin
            rdata_zero_reg <= mem_zero[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_one)
        begin
            mem_one[addr] <= wdata_one;
        end
        if (ctl.rd_en)
        begin
            rdata_one_reg <= mem_one[addr];
        end
    end

    assign rdata_zero = rdata_zero_reg;
    assign rdata_one  = rdata_one_reg;

endmodule

// ===== hw/rtl/adbs_seq.sv =====
// Sequencer: decodes each operation, walks the maps and holds the result beat.
`timescale 1ns / 1ps

module adbs_seq #(
    parameter int SET_BITS   = 1024,
    parameter int INDEX_BITS = 10,
    parameter int SET_BYTES  = 128,
    parameter int AW         = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            in_func,
    input  logic [15:0]           in_addr_tail,
    input  logic [6:0]            in_byte_index,
    input  logic [7:0]            in_merge_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_found,
    output logic [10:0]           out_bit_count,
    output logic [7:0]            out_read_byte,
    output adbs_pkg::map_ctl_t    ctl,
    output logic [AW-1:0]         addr,
    output logic [7:0]            wdata_zero,
    output logic [7:0]            wdata_one,
    input  logic [7:0]            rdata_zero,
    input  logic [7:0]            rdata_one
);
    import adbs_pkg::*;

    localparam logic [AW-1:0] LAST    = AW'(SET_BYTES - 1);
    localparam logic [7:0]    HI_MASK = 8'(8'hff >> (16 - INDEX_BITS));

    state_t        state_reg, state_next;
    logic [AW-1:0] cnt_reg;
    logic [2:0]    func_reg;
    logic [AW-1:0] addr_reg;
    logic [2:0]    bitpos_reg;
    logic [7:0]    mask_reg;
    logic          hit_reg;
    logic          sel_reg;
    logic          pend_reg;
    logic [10:0]   acc_reg;
    logic          res_found_reg;
    logic [7:0]    res_byte_reg;
    logic          out_valid_reg;
    logic          out_found_reg;
    logic [10:0]   out_count_reg;
    logic [7:0]    out_byte_reg;

    logic          accept;
    logic          out_free;
    logic          cnt_last;
    logic [15:0]   bit_idx;
    logic          bit_hit;
    logic          byte_hit;
    logic [7:0]    rdata_active;
    logic          is_write_op;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign cnt_last = (cnt_reg == LAST);

    assign bit_idx  = {in_addr_tail[15:8] & HI_MASK, in_addr_tail[7:0]};
    assign bit_hit  = (32'(bit_idx) < SET_BITS);
    assign byte_hit = (32'(in_byte_index) < SET_BYTES);

    assign rdata_active = sel_reg ? rdata_one : rdata_zero;
    assign is_write_op  = (func_reg == FN_INSERT) || (func_reg == FN_MERGE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_func) inside
                        FN_INSERT, FN_MERGE, FN_CONTAINS, FN_READ:
                            state_next = ST_ACCESS;
                        FN_SWAP:  state_next = ST_SWEEP;
                        FN_COUNT: state_next = ST_COUNT;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_ACCESS: state_next = ST_MODIFY;
            ST_MODIFY: state_next = ST_FINISH;
            ST_SWEEP:
            begin
                if (cnt_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_COUNT:
            begin
                if (cnt_last)
                begin
                    state_next = ST_COUNT_TAIL;
                end
            end
            ST_COUNT_TAIL: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory controls.
    always_comb
    begin
        ctl        = '0;
        addr       = addr_reg;
        wdata_zero = 8'd0;
        wdata_one  = 8'd0;
        in_ready   = 1'b0;
        unique case (state_reg) inside
            ST_INIT:
            begin
                ctl.wr_zero = 1'b1;
                ctl.wr_one  = 1'b1;
                addr        = cnt_reg;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_ACCESS:
            begin
                ctl.rd_en = 1'b1;
            end
            ST_MODIFY:
            begin
                ctl.wr_zero = hit_reg && is_write_op;
                ctl.wr_one  = hit_reg && is_write_op;
                wdata_zero  = rdata_zero | mask_reg;
                wdata_one   = rdata_one | mask_reg;
            end
            ST_SWEEP:
            begin
                // The role flag has already flipped; clear the map that was active.
                ctl.wr_zero = sel_reg;
                ctl.wr_one  = !sel_reg;
                addr        = cnt_reg;
            end
            ST_COUNT:
            begin
                ctl.rd_en = 1'b1;
                addr      = cnt_reg;
            end
            ST_COUNT_TAIL, ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            sel_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_INIT || state_reg == ST_SWEEP || state_reg == ST_COUNT)
            begin
                cnt_reg <= cnt_last ? '0 : cnt_reg + 1'b1;
            end
            if (accept && in_func == FN_SWAP)
            begin
                sel_reg <= !sel_reg;
            end
            pend_reg <= (state_reg == ST_COUNT);
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Operation payload and results.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg      <= in_func;
            res_found_reg <= 1'b0;
            res_byte_reg  <= 8'd0;
            acc_reg       <= 11'd0;
            if (in_func == FN_INSERT || in_func == FN_CONTAINS)
            begin
                addr_reg <= AW'(bit_idx[15:3]);
                mask_reg <= 8'(8'd1 << bit_idx[2:0]);
                hit_reg  <= bit_hit;
            end
            else
            begin
                addr_reg <= AW'(in_byte_index);
                mask_reg <= in_merge_byte;
                hit_reg  <= byte_hit;
            end
            bitpos_reg <= bit_idx[2:0];
        end
        if (state_reg == ST_MODIFY && hit_reg)
        begin
            if (func_reg == FN_CONTAINS)
            begin
                res_found_reg <= rdata_active[bitpos_reg];
            end
            if (func_reg == FN_READ)
            begin
                res_byte_reg <= rdata_active;
            end
        end
        // Read data arrives in the cycle after the walk address that fetched it.
        if ((state_reg == ST_COUNT && pend_reg) || state_reg == ST_COUNT_TAIL)
        begin
            acc_reg <= acc_reg + 11'(popcount8(rdata_active));
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            out_found_reg <= res_found_reg;
            out_count_reg <= acc_reg;
            out_byte_reg  <= res_byte_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_found     = out_found_reg;
    assign out_bit_count = out_count_reg;
    assign out_read_byte = out_byte_reg;

endmodule

// ===== hw/rtl/aged_double_bitmap_set_top.sv =====
// Top level of the aged double bitmap set: two bitmaps with ageing by swap.
`timescale 1ns / 1ps

// Each map is a single-port-per-direction memory of SET_BITS/8 bytes, and one
// sequencer drives both, so every operation is a short walk of memory accesses
// and the block takes one beat at a time. Insert, merge, contains and read go
// through a read state, a modify state that writes back for an in-range insert
// or merge, and a finish state that loads the output register once it is free.
// Swap and count visit every byte of a map one byte per cycle. After reset the
// block clears both maps and holds s_tready low until that pass is done. Every
// accepted beat gives exactly one result beat; fields that do not belong to the
// operation read as zero. A finished result waits in an output register, and
// the next beat is taken meanwhile.
module aged_double_bitmap_set_top #(
    parameter int SET_BITS   = 1024,
    parameter int INDEX_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // addr_tail[15:0], byte_index[22:16], merge_byte[30:23]
    input  logic [2:0]  s_tuser,   // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // found[0], bit_count[11:1], read_byte[19:12]
);
    import adbs_pkg::*;

    localparam int SET_BYTES = SET_BITS / 8;
    localparam int AW        = $clog2(SET_BYTES);

    map_ctl_t      ctl;
    logic [AW-1:0] addr;
    logic [7:0]    wdata_zero;
    logic [7:0]    wdata_one;
    logic [7:0]    rdata_zero;
    logic [7:0]    rdata_one;
    logic          found;
    logic [10:0]   bit_count;
    logic [7:0]    read_byte;

    adbs_seq #(
        .SET_BITS   (SET_BITS),
        .INDEX_BITS (INDEX_BITS),
        .SET_BYTES  (SET_BYTES),
        .AW         (AW)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_func       (s_tuser),
        .in_addr_tail  (s_tdata[15:0]),
        .in_byte_index (s_tdata[22:16]),
        .in_merge_byte (s_tdata[30:23]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_found     (found),
        .out_bit_count (bit_count),
        .out_read_byte (read_byte),
        .ctl           (ctl),
        .addr          (addr),
        .wdata_zero    (wdata_zero),
        .wdata_one     (wdata_one),
        .rdata_zero    (rdata_zero),
        .rdata_one     (rdata_one)
    );

    adbs_maps #(
        .SET_BYTES (SET_BYTES),
        .AW        (AW)
    ) u_maps (
        .clk        (clk),
        .ctl        (ctl),
        .addr       (addr),
        .wdata_zero (wdata_zero),
        .wdata_one  (wdata_one),
        .rdata_zero (rdata_zero),
        .rdata_one  (rdata_one)
    );

    assign m_tdata = {4'd0, read_byte, bit_count, found};

`ifndef SYNTHESIS
    // The map memories are never read and written in the same cycle.
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.rd_en && (ctl.wr_zero || ctl.wr_one)))
        else $error("map read and write in the same cycle");

    // While the block waits for a beat, nothing touches the maps.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(ctl.wr_zero || ctl.wr_one || ctl.rd_en))
        else $error("map access while waiting for a beat");

    // One beat at a time: ready drops right after a beat is taken.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat taken while an operation runs");
`endif

endmodule

// ===== tb/sv/tb_aged_double_bitmap_set_top.sv =====
// Self-checking testbench for the aged double bitmap set with stream-side stalls.
`timescale 1ns / 1ps

module tb_aged_double_bitmap_set_top;

    import adbs_pkg::*;

    localparam int SET_BITS       = 1024;
    localparam int INDEX_BITS     = 10;
    localparam int SET_BYTES      = SET_BITS / 8;
    localparam int POOL_DEPTH     = 32;
    localparam int RANDOM_ITEMS   = 900;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRINT_CAP      = 100;

    // Codes outside the defined operation set; the block must answer them with zeros and leave the maps alone.
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] bit_count;
        logic [BYTE_W-1:0]  read_byte;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // addr_tail[15:0], byte_index[22:16], merge_byte[30:23]
    logic [2:0]  s_tuser;   // func[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // found[0], bit_count[11:1], read_byte[19:12]

    // Shadow copy of both bitmaps and of the active-map select.
    logic [7:0]  bank0 [SET_BYTES];
    logic [7:0]  bank1 [SET_BYTES];
    logic        live_bank;

    answer_t     pending_answers[$];
    logic [15:0] inserted_addrs[$];
    int          mismatch_count;
    int          answer_index;
    int          quiet_cycles;
    bit          steady_flow;

    aged_double_bitmap_set_top #(
        .SET_BITS   (SET_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned bit_pos(input logic [15:0] addr);
        logic [7:0] hi_mask;
        hi_mask = 8'hff >> (16 - INDEX_BITS);
        return ({24'd0, addr[15:8] & hi_mask} << 8) + {24'd0, addr[7:0]};
    endfunction

    // Applies one operation to the shadow maps and returns the answer it gives.
    function automatic answer_t bitmap_apply(input logic [2:0] op, input logic [15:0] addr,
                                             input logic [6:0] bidx, input logic [7:0] mbyte);
        answer_t     ans;
        int unsigned pos;
        int unsigned total;
        ans   = '0;
        pos   = bit_pos(addr);
        total = 0;
        case (op)
            FN_INSERT:
            begin
                if (pos < SET_BITS)
                begin
                    bank0[pos / 8][pos % 8] = 1'b1;
                    bank1[pos / 8][pos % 8] = 1'b1;
                end
            end
            FN_MERGE:
            begin
                if (bidx < SET_BYTES)
                begin
                    bank0[bidx] = bank0[bidx] | mbyte;
                    bank1[bidx] = bank1[bidx] | mbyte;
                end
            end
            FN_CONTAINS:
            begin
                if (pos < SET_BITS)
                    ans.found = live_bank ? bank1[pos / 8][pos % 8] : bank0[pos / 8][pos % 8];
            end
            FN_SWAP:
            begin
                live_bank = ~live_bank;
                for (int k = 0; k < SET_BYTES; k++)
                begin
                    if (live_bank)
                        bank0[k] = 8'd0;
                    else
                        bank1[k] = 8'd0;
                end
            end
            FN_COUNT:
            begin
                for (int k = 0; k < SET_BYTES; k++)
                    total += $countones(live_bank ? bank1[k] : bank0[k]);
                ans.bit_count = total[COUNT_W-1:0];
            end
            FN_READ:
            begin
                if (bidx < SET_BYTES)
                    ans.read_byte = live_bank ? bank1[bidx] : bank0[bidx];
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    // Mostly short gaps, a few long ones; none while steady flow is requested.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at answer %0d: %s got %0d expected %0d",
                     answer_index, what, got, want);
        mismatch_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic [2:0] op, input logic [15:0] addr,
                             input logic [6:0] bidx, input logic [7:0] mbyte);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {1'b0, mbyte, bidx, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_answers.push_back(bitmap_apply(op, addr, bidx, mbyte));
        if (op == FN_INSERT)
        begin
            inserted_addrs.push_back(addr);
            if (inserted_addrs.size() > POOL_DEPTH)
                void'(inserted_addrs.pop_front());
        end
        @(negedge clk);
    endtask

    task automatic test_empty_state();
        send_beat(FN_COUNT, 16'h0000, 7'd0, 8'h00);
        send_beat(FN_READ, 16'h0000, 7'd0, 8'h00);
        send_beat(FN_READ, 16'h0000, 7'd127, 8'h00);
        send_beat(FN_CONTAINS, 16'hffff, 7'd0, 8'h00);
    endtask

    task automatic test_insert_lookup();
        send_beat(FN_INSERT, 16'h0000, 7'd0, 8'h00);
        send_beat(FN_INSERT, 16'hffff, 7'd0, 8'h00);
        send_beat(FN_CONTAINS, 16'hffff, 7'd0, 8'h00);
        // Upper address bits beyond the index width are dropped, so this hits bit zero.
        send_beat(FN_CONTAINS, 16'hfc00, 7'd0, 8'h00);
        send_beat(FN_CONTAINS, 16'h0001, 7'd0, 8'h00);
        send_beat(FN_CONTAINS, 16'h03fe, 7'd0, 8'h00);
    endtask

    task automatic test_merge_read();
        send_beat(FN_MERGE, 16'h0000, 7'd127, 8'h01);
        send_beat(FN_MERGE, 16'h0000, 7'd0, 8'h80);
        send_beat(FN_MERGE, 16'h0000, 7'd64, 8'h5a);
        send_beat(FN_READ, 16'h0000, 7'd127, 8'h00);
        send_beat(FN_READ, 16'h0000, 7'd0, 8'h00);
        send_beat(FN_READ, 16'h0000, 7'd64, 8'h00);
        send_beat(FN_COUNT, 16'h0000, 7'd0, 8'h00);
    endtask

    // Entries not refreshed between two swaps must drop out.
    task automatic test_swap_ageing();
        send_beat(FN_SWAP, 16'h0000, 7'd0, 8'h00);
        send_beat(FN_CONTAINS, 16'hffff, 7'd0, 8'h00);
        send_beat(FN_INSERT, 16'h0155, 7'd0, 8'h00);
        send_beat(FN_SWAP, 16'h0000, 7'd0, 8'h00);
        send_beat(FN_CONTAINS, 16'h0155, 7'd0, 8'h00);
        send_beat(FN_COUNT, 16'h0000, 7'd0, 8'h00);
    endtask

    task automatic test_unknown_codes();
        send_beat(FUNC_RSVD6, 16'hffff, 7'd127, 8'hff);
        send_beat(FUNC_RSVD7, 16'hffff, 7'd127, 8'hff);
    endtask

    // Saturates both maps to reach the largest count, then ages everything out.
    task automatic test_full_map();
        for (int k = 0; k < SET_BYTES; k++)
            send_beat(FN_MERGE, 16'(k), 7'(k), 8'hff);
        send_beat(FN_COUNT, 16'h0000, 7'd0, 8'h00);
        send_beat(FN_SWAP, 16'h0000, 7'd0, 8'h00);
        send_beat(FN_COUNT, 16'h0000, 7'd0, 8'h00);
        send_beat(FN_SWAP, 16'h0000, 7'd0, 8'h00);
        send_beat(FN_COUNT, 16'h0000, 7'd0, 8'h00);
    endtask

    task automatic test_random_traffic();
        int          r;
        logic [15:0] addr;
        logic [15:0] ignored_bits;
        logic [7:0]  mbyte;
        ignored_bits = ~16'((1 << INDEX_BITS) - 1);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
                steady_flow = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            addr = 16'($urandom);
            // Lookups mostly target known members, with the ignored bits scrambled.
            if (inserted_addrs.size() > 0 && $urandom_range(0, 9) < 7)
                addr = inserted_addrs[$urandom_range(0, inserted_addrs.size() - 1)]
                       ^ (16'($urandom) & ignored_bits);
            mbyte = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h01 << $urandom_range(0, 7);
            if (r < 28)
                send_beat(FN_INSERT, 16'($urandom), 7'($urandom), 8'($urandom));
            else if (r < 50)
                send_beat(FN_CONTAINS, addr, 7'($urandom), 8'($urandom));
            else if (r < 66)
                send_beat(FN_MERGE, 16'($urandom), 7'($urandom), mbyte);
            else if (r < 82)
                send_beat(FN_READ, 16'($urandom), 7'($urandom), 8'($urandom));
            else if (r < 88)
                send_beat(FN_SWAP, 16'($urandom), 7'($urandom), 8'($urandom));
            else if (r < 93)
                send_beat(FN_COUNT, 16'($urandom), 7'($urandom), 8'($urandom));
            else if (r < 96)
                send_beat($urandom_range(0, 1) ? FUNC_RSVD6 : FUNC_RSVD7,
                          16'($urandom), 7'($urandom), 8'($urandom));
            else
            begin
                addr = 16'($urandom);
                send_beat(FN_INSERT, addr, 7'($urandom), 8'($urandom));
                send_beat(FN_CONTAINS, addr ^ (16'($urandom) & ignored_bits),
                          7'($urandom), 8'($urandom));
            end
        end
        steady_flow = 1'b0;
    endtask

    // Result side: bursts of ready separated by stalls of random length.
    initial
    begin
        int run;
        int hold;
        m_tready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            run = steady_flow ? 1 : $urandom_range(1, 16);
            m_tready = 1'b1;
            repeat (run) @(negedge clk);
            hold = pick_gap();
            if (hold > 0)
            begin
                m_tready = 1'b0;
                repeat (hold) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                report_mismatch("unexpected result beat, found", int'(m_tdata[0]), 0);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (m_tdata[0] !== want.found)
                    report_mismatch("found", int'(m_tdata[0]), int'(want.found));
                if (m_tdata[11:1] !== want.bit_count)
                    report_mismatch("bit_count", int'(m_tdata[11:1]), int'(want.bit_count));
                if (m_tdata[19:12] !== want.read_byte)
                    report_mismatch("read_byte", int'(m_tdata[19:12]), int'(want.read_byte));
            end
            answer_index++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_aged_double_bitmap_set_top: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        steady_flow    = 1'b0;
        mismatch_count = 0;
        answer_index   = 0;
        quiet_cycles   = 0;
        live_bank      = 1'b0;
        for (int k = 0; k < SET_BYTES; k++)
        begin
            bank0[k] = 8'd0;
            bank1[k] = 8'd0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_state();
        test_insert_lookup();
        test_merge_read();
        test_swap_ageing();
        test_unknown_codes();
        test_full_map();
        test_random_traffic();
        s_tvalid = 1'b0;

        while (pending_answers.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_aged_double_bitmap_set_top: PASS");
        else
            $display("tb_aged_double_bitmap_set_top: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/adbs_pkg.sv
hw/rtl/adbs_maps.sv
hw/rtl/adbs_seq.sv
hw/rtl/aged_double_bitmap_set_top.sv
tb/sv/tb_aged_double_bitmap_set_top.sv
